### design/modexp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modexp_pkg: shared types and constants for the modular exponentiation block
// Default operand width and the sequencer state encoding.
// ----------------------------------------------------------------------------
package modexp_pkg;

   localparam int WIDTH_DEFAULT = 32;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_CHECK,
      ST_MUL_ACC,
      ST_MUL_SQ,
      ST_DONE
   } state_type;

endpackage

### design/modular_exponentiation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modular_exponentiation: square-and-multiply modular exponentiation
// Returns base^exponent mod modulus using a shared bit-serial modular
// multiplier, scanning the exponent from its least significant bit.
//
//   channel  direction  beat fields
//   req      in         base, exponent, modulus
//   rsp      out        remainder
//
// one item at a time; all modular products run on the shared multiplier:
// the base reduction, then per exponent bit a multiply if set and a square;
// the scan stops after the highest set exponent bit. modulus 0 or 1 answers 0
// without the multiplier. a finished beat waits in the rsp register; a new req
// beat is taken once that register has been loaded.
// reset is synchronous and clears control state only.
// ----------------------------------------------------------------------------
module modular_exponentiation #(
   parameter int WIDTH = modexp_pkg::WIDTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [WIDTH-1:0] req_base,
   input  logic [WIDTH-1:0] req_exponent,
   input  logic [WIDTH-1:0] req_modulus,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [WIDTH-1:0] rsp_remainder
);

   localparam logic [WIDTH-1:0] ONE = WIDTH'(1);

   modexp_pkg::state_type state_ff, state_in;

   logic [WIDTH-1:0] exp_ff, exp_in;
   logic [WIDTH-1:0] n_ff, n_in;
   logic [WIDTH-1:0] acc_ff, acc_in;
   logic [WIDTH-1:0] sq_ff, sq_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [WIDTH-1:0] rsp_rem_ff, rsp_rem_in;

   logic             accept;
   logic             trivial;
   logic             mm_start;
   logic [WIDTH-1:0] mm_a;
   logic [WIDTH-1:0] mm_b;
   logic [WIDTH-1:0] mm_n;
   logic             mm_done;
   logic [WIDTH-1:0] mm_result;
   logic             out_free;

   assign req_ready = (state_ff == modexp_pkg::ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign trivial   = (req_modulus[WIDTH-1:1] == '0);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   modexp_mulmod #(
      .WIDTH(WIDTH)
   ) u_mulmod (
      .clock  (clock),
      .reset  (reset),
      .start  (mm_start),
      .op_a   (mm_a),
      .op_b   (mm_b),
      .op_n   (mm_n),
      .done   (mm_done),
      .result (mm_result)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         modexp_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = trivial ? modexp_pkg::ST_DONE : modexp_pkg::ST_REDUCE;
            end
         end
         modexp_pkg::ST_REDUCE: begin
            if (mm_done) begin
               state_in = modexp_pkg::ST_CHECK;
            end
         end
         modexp_pkg::ST_CHECK: begin
            if (exp_ff == '0) begin
               state_in = modexp_pkg::ST_DONE;
            end else if (exp_ff[0]) begin
               state_in = modexp_pkg::ST_MUL_ACC;
            end else begin
               state_in = modexp_pkg::ST_MUL_SQ;
            end
         end
         modexp_pkg::ST_MUL_ACC: begin
            if (mm_done) begin
               state_in = (exp_ff[WIDTH-1:1] == '0) ? modexp_pkg::ST_DONE
                                                     : modexp_pkg::ST_MUL_SQ;
            end
         end
         modexp_pkg::ST_MUL_SQ: begin
            if (mm_done) begin
               state_in = modexp_pkg::ST_CHECK;
            end
         end
         modexp_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = modexp_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = modexp_pkg::ST_IDLE;
         end
      endcase
   end

   // outputs and datapath
   always_comb begin
      mm_start     = 1'b0;
      mm_a         = sq_ff;
      mm_b         = sq_ff;
      mm_n         = n_ff;
      exp_in       = exp_ff;
      n_in         = n_ff;
      acc_in       = acc_ff;
      sq_in        = sq_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_rem_in   = rsp_rem_ff;
      case (state_ff)
         modexp_pkg::ST_IDLE: begin
            if (accept) begin
               exp_in = req_exponent;
               n_in   = req_modulus;
               // zero for a trivial modulus, otherwise one
               acc_in = trivial ? '0 : ONE;
               mm_a   = ONE;
               mm_b   = req_base;
               mm_n   = req_modulus;
               // base mod n as (1 * base) mod n
               mm_start = !trivial;
            end
         end
         modexp_pkg::ST_REDUCE: begin
            if (mm_done) begin
               sq_in = mm_result;
            end
         end
         modexp_pkg::ST_CHECK: begin
            if (exp_ff != '0) begin
               mm_start = 1'b1;
               mm_a     = exp_ff[0] ? acc_ff : sq_ff;
            end
         end
         modexp_pkg::ST_MUL_ACC: begin
            if (mm_done) begin
               acc_in   = mm_result;
               mm_start = (exp_ff[WIDTH-1:1] != '0);
            end
         end
         modexp_pkg::ST_MUL_SQ: begin
            if (mm_done) begin
               sq_in  = mm_result;
               exp_in = {1'b0, exp_ff[WIDTH-1:1]};
            end
         end
         modexp_pkg::ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_rem_in   = acc_ff;
            end
         end
         default: begin
            mm_start = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= modexp_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      exp_ff     <= exp_in;
      n_ff       <= n_in;
      acc_ff     <= acc_in;
      sq_ff      <= sq_in;
      rsp_rem_ff <= rsp_rem_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_remainder = rsp_rem_ff;

endmodule

### design/modexp_mulmod.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modexp_mulmod: bit-serial modular multiplier
// Computes (a * b) mod n, one multiplier bit per cycle, most significant bit
// first, keeping the partial product reduced below n at every step.
// ----------------------------------------------------------------------------
module modexp_mulmod #(
   parameter int WIDTH = modexp_pkg::WIDTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] op_a,
   input  logic [WIDTH-1:0] op_b,
   input  logic [WIDTH-1:0] op_n,
   output logic             done,
   output logic [WIDTH-1:0] result
);

   localparam int CNT_W = $clog2(WIDTH + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [WIDTH-1:0] a_ff, a_in;
   logic [WIDTH-1:0] b_ff, b_in;
   logic [WIDTH-1:0] n_ff, n_in;
   logic [WIDTH-1:0] acc_ff, acc_in;

   logic [WIDTH+1:0] sum;
   logic [WIDTH+1:0] diff1;
   logic [WIDTH+1:0] diff2;
   logic [WIDTH-1:0] step;

   // 2*acc + bit*a stays below 3n, so one of three candidates is in range
   always_comb begin
      sum   = {1'b0, acc_ff, 1'b0} + (b_ff[WIDTH-1] ? {2'b00, a_ff} : '0);
      diff1 = sum - {2'b00, n_ff};
      diff2 = sum - {1'b0, n_ff, 1'b0};
      if (!diff2[WIDTH+1]) begin
         step = diff2[WIDTH-1:0];
      end else if (!diff1[WIDTH+1]) begin
         step = diff1[WIDTH-1:0];
      end else begin
         step = sum[WIDTH-1:0];
      end
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      n_in    = n_ff;
      acc_in  = acc_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(WIDTH);
         a_in    = op_a;
         b_in    = op_b;
         n_in    = op_n;
         acc_in  = '0;
      end else if (busy_ff) begin
         acc_in = step;
         b_in   = {b_ff[WIDTH-2:0], 1'b0};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      a_ff   <= a_in;
      b_ff   <= b_in;
      n_ff   <= n_in;
      acc_ff <= acc_in;
   end

   assign done   = done_ff;
   assign result = acc_ff;

endmodule

### bench/tb_modular_exponentiation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_modular_exponentiation: self-checking bench for modular exponentiation
// A short table of directed beats covers the operand extremes, exponent zero,
// modulus one and zero. About 290 random beats follow. Each result is checked
// in order of arrival against its row's known value or a square-and-multiply
// predictor. Both channels idle at random; the sender drains the block more than once.
// ----------------------------------------------------------------------------
module tb_modular_exponentiation;

   localparam int W            = modexp_pkg::WIDTH_DEFAULT;
   localparam int RANDOM_ITEMS = 290;
   localparam int QUIET_LIMIT  = 20000;
   localparam int TAIL_CYCLES  = 2500;
   localparam int NUM_DIRECTED = 21;

   localparam logic [W-1:0] ALL_ONES = '1;
   localparam logic [W-1:0] TOP_BIT  = ALL_ONES ^ (ALL_ONES >> 1);

   typedef struct {
      logic [W-1:0] base;
      logic [W-1:0] exponent;
      logic [W-1:0] modulus;
      bit           known;
      logic [W-1:0] remainder;
   } vector_row_type;

   // rows with known set carry the result read straight off the definition
   vector_row_type directed_rows [NUM_DIRECTED] = '{
      '{'0,           '0,           W'(1),        1'b1, '0},
      '{W'(1),        W'(1),        W'(1),        1'b1, '0},
      '{ALL_ONES,     ALL_ONES,     W'(1),        1'b1, '0},
      '{ALL_ONES,     ALL_ONES,     '0,           1'b1, '0},
      '{W'(123),      '0,           '0,           1'b1, '0},
      '{W'(5),        '0,           W'(7),        1'b1, W'(1)},
      '{'0,           '0,           ALL_ONES,     1'b1, W'(1)},
      '{ALL_ONES,     '0,           W'(2),        1'b1, W'(1)},
      '{'0,           W'(5),        W'(13),       1'b1, '0},
      '{'0,           ALL_ONES,     ALL_ONES,     1'b1, '0},
      '{W'(1),        ALL_ONES,     ALL_ONES,     1'b1, W'(1)},
      '{ALL_ONES,     W'(1),        ALL_ONES,     1'b1, '0},
      '{W'(3),        W'(1),        W'(2),        1'b1, W'(1)},
      '{W'(2),        W'(10),       W'(1000),     1'b1, W'(24)},
      '{ALL_ONES,     W'(2),        ALL_ONES - 1, 1'b0, '0},
      '{ALL_ONES - 1, ALL_ONES,     ALL_ONES,     1'b0, '0},
      '{W'(32'h12345678), W'(32'hdeadbeef), W'(32'hfffffffb), 1'b0, '0},
      '{W'(7),        TOP_BIT,      ALL_ONES >> 1, 1'b0, '0},
      '{ALL_ONES,     ALL_ONES,     TOP_BIT,      1'b0, '0},
      '{W'(2),        W'(W-1),      ALL_ONES,     1'b0, '0},
      '{TOP_BIT,      W'(2),        ALL_ONES,     1'b0, '0}
   };

   logic         clock         = 1'b0;
   logic         reset         = 1'b1;
   logic         req_valid     = 1'b0;
   logic         req_ready;
   logic [W-1:0] req_base      = '0;
   logic [W-1:0] req_exponent  = '0;
   logic [W-1:0] req_modulus   = '0;
   logic         rsp_valid;
   logic         rsp_ready     = 1'b0;
   logic [W-1:0] rsp_remainder;

   logic [W-1:0] remainder_q [$];
   logic [W-1:0] want_remainder;
   int           errors        = 0;
   int           hold_left     = 0;
   int           quiet_cycles  = 0;
   bit           calm          = 1'b0;

   modular_exponentiation #(
      .WIDTH(W)
   ) i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_base      (req_base),
      .req_exponent  (req_exponent),
      .req_modulus   (req_modulus),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_remainder (rsp_remainder)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // square and multiply with double-width products
   function automatic logic [W-1:0] power_mod(input logic [W-1:0] b,
                                              input logic [W-1:0] e,
                                              input logic [W-1:0] n);
      logic [2*W-1:0] acc;
      logic [2*W-1:0] sq;
      logic [2*W-1:0] nn;
      int             i;
      if (n <= 1) return '0;
      nn  = {{W{1'b0}}, n};
      acc = (2*W)'(1);
      sq  = {{W{1'b0}}, b % n};
      for (i = 0; i < W; i++) begin
         if (e[i]) acc = (acc * sq) % nn;
         sq = (sq * sq) % nn;
      end
      return acc[W-1:0];
   endfunction

   function automatic int pick_gap();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 20);
      return $urandom_range(40, 200);
   endfunction

   // holds the beat until taken, then queues its expected remainder
   task automatic send_beat(input logic [W-1:0] b, input logic [W-1:0] e,
                            input logic [W-1:0] n, input bit known,
                            input logic [W-1:0] known_remainder);
      req_valid    <= 1'b1;
      req_base     <= b;
      req_exponent <= e;
      req_modulus  <= n;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      remainder_q.push_back(known ? known_remainder : power_mod(b, e, n));
   endtask

   task automatic idle_gap();
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain_results();
      if (remainder_q.size() != 0) begin
         req_valid <= 1'b0;
         while (remainder_q.size() != 0) @(posedge clock);
      end
   endtask

   // result channel: check each beat, then pick the next ready
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (remainder_q.size() == 0) begin
            $display("%0t: unexpected rsp beat, expected none actual %h",
                     $time, rsp_remainder);
            errors++;
         end else begin
            want_remainder = remainder_q.pop_front();
            if (rsp_remainder !== want_remainder) begin
               $display("%0t: remainder expected %h actual %h",
                        $time, want_remainder, rsp_remainder);
               errors++;
            end
         end
      end
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left--;
      end else begin
         rsp_ready <= 1'b1;
         if ($urandom_range(0, 7) == 0) hold_left = pick_gap();
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles == QUIET_LIMIT) begin
         $display("modular_exponentiation: mismatch");
         $finish;
      end
   end

   initial begin
      logic [W-1:0] b;
      logic [W-1:0] e;
      logic [W-1:0] n;
      int           k;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (k = 0; k < NUM_DIRECTED; k++) begin
         send_beat(directed_rows[k].base, directed_rows[k].exponent,
                   directed_rows[k].modulus, directed_rows[k].known,
                   directed_rows[k].remainder);
         idle_gap();
      end
      drain_results();

      for (k = 0; k < RANDOM_ITEMS; k++) begin
         if (k % 40 == 0) calm = ($urandom_range(0, 3) == 0);
         if (k == 100 || k == 200) drain_results();
         b = $urandom;
         e = $urandom;
         n = $urandom;
         if (n == 0) n = 1;
         case ($urandom_range(0, 9))
            0, 1, 2: ;
            3, 4: e = $urandom_range(0, 255);
            5: n = $urandom_range(1, 16);
            6: n = ALL_ONES - $urandom_range(0, 15);
            7: begin
               case ($urandom_range(0, 4))
                  0: b = '0;
                  1: b = 1;
                  2: b = ALL_ONES;
                  3: b = n - 1;
                  default: b = n;
               endcase
            end
            8: begin
               case ($urandom_range(0, 2))
                  0: begin
                     e = '0;
                     e[$urandom_range(0, W-1)] = 1'b1;
                  end
                  1: e = ALL_ONES;
                  default: e = $urandom_range(0, 3);
               endcase
            end
            default: begin
               n = $urandom_range(2, 1000);
               b = $urandom_range(0, 2000);
            end
         endcase
         send_beat(b, e, n, 1'b0, '0);
         idle_gap();
      end

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (errors == 0 && remainder_q.size() == 0) begin
         $display("modular_exponentiation: match");
      end else begin
         $display("modular_exponentiation: mismatch");
      end
      $finish;
   end

endmodule
